>>> hdl/frame_bitmap_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame bitmap allocator
// Shared property forms used by the allocator controller.
// ----------------------------------------------------------------------------
`ifndef FRAME_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define FBA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define FBA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define FBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/fba_pkg.sv
// ----------------------------------------------------------------------------
// Frame bitmap allocator package
// Sizes, result codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int NumFrames = 4096;
  localparam int WordBits  = 32;
  localparam int NumWords  = NumFrames / WordBits;
  localparam int WordIdxW  = $clog2(NumWords);
  localparam int BitIdxW   = $clog2(WordBits);
  localparam int FrameW    = 12;
  localparam int CfgW      = 8;
  localparam int StatusW   = 3;

  localparam logic [CfgW-1:0] ActiveReset = CfgW'(NumWords);
  localparam logic [CfgW-1:0] NumWordsCfg = CfgW'(NumWords);

  typedef enum logic [StatusW-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_HAD_FRAME = 3'd1,
    ST_FULL      = 3'd2,
    ST_FREED     = 3'd3,
    ST_NOTHING   = 3'd4
  } status_t;

  typedef struct packed {
    logic    capture;
    logic    scan_clear;
    logic    scan_rd;
    logic    free_rd;
    logic    mem_wr;
    logic    res_set;
    status_t res_code;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic func_free;
    logic entry_zero;
    logic hit;
    logic issue_more;
    logic out_busy;
  } stat_t;

endpackage

>>> hdl/fba_datapath.sv
// ----------------------------------------------------------------------------
// Frame bitmap allocator datapath
// Bitmap memory, scan counter, first-clear-bit search and result registers.
// ----------------------------------------------------------------------------
module fba_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  fba_pkg::cmd_t                cmd,
  output fba_pkg::stat_t               stat,
  input  logic                         func,
  input  logic [fba_pkg::FrameW-1:0]   entry_frame,
  input  logic                         kernel_page,
  input  logic                         grant_write,
  input  logic                         cfg_wr,
  input  logic [fba_pkg::CfgW-1:0]     cfg_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fba_pkg::FrameW-1:0]   frame,
  output logic                         present,
  output logic                         writable,
  output logic                         user_mode,
  output logic [fba_pkg::StatusW-1:0]  status
);

  logic [fba_pkg::WordBits-1:0] bitmap_mem [fba_pkg::NumWords];
  logic [fba_pkg::NumWords-1:0] word_valid;

  logic                         func_q;
  logic [fba_pkg::FrameW-1:0]   entry_q;
  logic                         kernel_q;
  logic                         writeable_q;

  logic [fba_pkg::CfgW-1:0]     active_words;
  logic [fba_pkg::CfgW-1:0]     limit;
  logic [fba_pkg::WordIdxW:0]   issue_cnt;

  logic [fba_pkg::WordIdxW-1:0] rd_addr;
  logic [fba_pkg::WordIdxW-1:0] rd_idx;
  logic [fba_pkg::WordBits-1:0] rd_data;
  logic                         rd_vld;
  logic [fba_pkg::WordBits-1:0] word_eff;
  logic [fba_pkg::BitIdxW-1:0]  bit_idx;
  logic [fba_pkg::WordBits-1:0] wr_data;

  logic [fba_pkg::FrameW-1:0]   res_frame;
  fba_pkg::status_t             res_status;
  logic                         res_alloc;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q      <= func;
      entry_q     <= entry_frame;
      kernel_q    <= kernel_page;
      writeable_q <= grant_write;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_words <= fba_pkg::ActiveReset;
    end else if (cfg_wr) begin
      active_words <= cfg_data;
    end
  end

  assign limit = (active_words > fba_pkg::NumWordsCfg) ? fba_pkg::NumWordsCfg : active_words;

  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      issue_cnt <= '0;
    end else if (cmd.scan_rd) begin
      issue_cnt <= issue_cnt + 1'b1;
    end
  end

  assign rd_addr = cmd.free_rd ? entry_q[fba_pkg::FrameW-1:fba_pkg::BitIdxW]
                               : issue_cnt[fba_pkg::WordIdxW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.free_rd) begin
      rd_data <= bitmap_mem[rd_addr];
      rd_vld  <= word_valid[rd_addr];
      rd_idx  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      bitmap_mem[rd_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (cmd.mem_wr) begin
      word_valid[rd_idx] <= 1'b1;
    end
  end

  assign word_eff = rd_vld ? rd_data : '0;

  always_comb begin
    bit_idx = '0;
    for (int i = fba_pkg::WordBits - 1; i >= 0; i--) begin
      if (!word_eff[i]) begin
        bit_idx = fba_pkg::BitIdxW'(i);
      end
    end
  end

  always_comb begin
    if (func_q) begin
      wr_data = word_eff & ~(fba_pkg::WordBits'(1) << entry_q[fba_pkg::BitIdxW-1:0]);
    end else begin
      wr_data = word_eff | (fba_pkg::WordBits'(1) << bit_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status <= cmd.res_code;
      case (cmd.res_code)
        fba_pkg::ST_ALLOCATED: res_frame <= {rd_idx, bit_idx};
        fba_pkg::ST_HAD_FRAME: res_frame <= entry_q;
        default:               res_frame <= '0;
      endcase
    end
  end

  assign res_alloc = (res_status == fba_pkg::ST_ALLOCATED);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      frame     <= res_frame;
      status    <= res_status;
      present   <= res_alloc;
      writable  <= res_alloc & writeable_q;
      user_mode <= res_alloc & ~kernel_q;
    end
  end

  assign stat.func_free  = func_q;
  assign stat.entry_zero = (entry_q == '0);
  assign stat.hit        = (word_eff != '1);
  assign stat.issue_more = (fba_pkg::CfgW'(issue_cnt) < limit);
  assign stat.out_busy   = out_valid && out_stall;

endmodule

>>> hdl/fba_controller.sv
// ----------------------------------------------------------------------------
// Frame bitmap allocator controller
// Sequences decode, word scan, free read-modify-write and result hand-off.
// ----------------------------------------------------------------------------
`include "frame_bitmap_allocator_unit_assert.svh"

module fba_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  fba_pkg::stat_t stat,
  output fba_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FREE_WR,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   pend;
  logic   pend_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    pend_next  = pend;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.func_free) begin
          if (!stat.entry_zero) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = fba_pkg::ST_HAD_FRAME;
            state_next   = S_DONE;
          end else begin
            cmd.scan_clear = 1'b1;
            pend_next      = 1'b0;
            state_next     = S_SCAN;
          end
        end else if (stat.entry_zero) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = fba_pkg::ST_NOTHING;
          state_next   = S_DONE;
        end else begin
          cmd.free_rd = 1'b1;
          state_next  = S_FREE_WR;
        end
      end
      S_SCAN: begin
        if (pend && stat.hit) begin
          cmd.mem_wr   = 1'b1;
          cmd.res_set  = 1'b1;
          cmd.res_code = fba_pkg::ST_ALLOCATED;
          state_next   = S_DONE;
        end else if (stat.issue_more) begin
          cmd.scan_rd = 1'b1;
          pend_next   = 1'b1;
        end else begin
          cmd.res_set  = 1'b1;
          cmd.res_code = fba_pkg::ST_FULL;
          state_next   = S_DONE;
        end
      end
      S_FREE_WR: begin
        cmd.mem_wr   = 1'b1;
        cmd.res_set  = 1'b1;
        cmd.res_code = fba_pkg::ST_FREED;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  `FBA_ASSERT_IMPLIES(a_wr_state, clk, rst, cmd.mem_wr, (state == S_SCAN) || (state == S_FREE_WR), "Bitmap write outside scan or free.")
  `FBA_ASSERT_IMPLIES(a_load_free, clk, rst, cmd.load_out, !stat.out_busy, "Result loaded over a stalled transaction.")
  `FBA_ASSERT_ALWAYS(a_one_port, clk, rst, $onehot0({cmd.scan_rd, cmd.free_rd, cmd.mem_wr}), "Bitmap port used twice in one cycle.")
  `FBA_ASSERT_NEXT(a_accept_decode, clk, rst, in_valid && !in_stall, state == S_DECODE, "Accepted transaction not decoded.")

endmodule

>>> hdl/frame_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// Frame bitmap allocator
// First-fit page frame allocator over a 4096-frame bitmap.
// ----------------------------------------------------------------------------
// Requests enter on the input channel (in_valid/in_stall) with func,
// entry_frame, kernel_page and grant_write. Each request yields one result
// transaction on the output channel (out_valid/out_stall) carrying frame,
// present, writable, user_mode and status.
// The active_words register is written through cfg_valid/cfg_ready/cfg_data,
// which is always ready and must be used only while the block is idle.
// One request is processed at a time. An allocation scans the 128-word bitmap
// memory one word per cycle through its single port, searching the first
// active_words words, capped at 128. A free is a read-modify-write of one word.
// Reset clears the bitmap through per-word valid flags and sets active_words to
// 128. A stalled result holds in the output register; a finished request waits
// for it before the next request is accepted.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         func,
  input  logic [fba_pkg::FrameW-1:0]   entry_frame,
  input  logic                         kernel_page,
  input  logic                         grant_write,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fba_pkg::FrameW-1:0]   frame,
  output logic                         present,
  output logic                         writable,
  output logic                         user_mode,
  output logic [fba_pkg::StatusW-1:0]  status,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fba_pkg::CfgW-1:0]     cfg_data
);

  fba_pkg::cmd_t  cmd;
  fba_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  fba_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fba_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (func),
    .entry_frame  (entry_frame),
    .kernel_page  (kernel_page),
    .grant_write  (grant_write),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame        (frame),
    .present      (present),
    .writable     (writable),
    .user_mode    (user_mode),
    .status       (status)
  );

endmodule

>>> tb/frame_bitmap_allocator_tb_pkg.sv
// ----------------------------------------------------------------------------
// Frame bitmap allocator testbench types
// Request codes shared by the checker and the stimulus, and the checker's result entry.
// ----------------------------------------------------------------------------
package frame_bitmap_allocator_tb_pkg;

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } request_fn_t;

  typedef struct packed {
    logic [fba_pkg::FrameW-1:0] frame;
    logic                       present;
    logic                       writable;
    logic                       user_mode;
    fba_pkg::status_t           status;
  } page_entry_t;

endpackage

>>> tb/frame_bitmap_allocator_checker.sv
// ----------------------------------------------------------------------------
// Frame bitmap allocator checker
// Watches the request, result and register channels, keeps its own frame
// bitmap and search limit, and compares every result transaction in order.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_checker
  import fba_pkg::*;
  import frame_bitmap_allocator_tb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                func,
  input  logic [FrameW-1:0]   entry_frame,
  input  logic                kernel_page,
  input  logic                grant_write,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [FrameW-1:0]   frame,
  input  logic                present,
  input  logic                writable,
  input  logic                user_mode,
  input  logic [StatusW-1:0]  status,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgW-1:0]     cfg_data,
  output int                  mismatches,
  output int                  pending
);

  logic [WordBits-1:0] frame_bitmap [NumWords];
  logic [CfgW-1:0]     search_words;
  page_entry_t         pending_entries [$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  task automatic report(input string line);
    $display("%s", line);
    mismatches++;
  endtask

  function automatic page_entry_t serve_request(input request_fn_t fn,
                                                input logic [FrameW-1:0] entry,
                                                input logic kernel,
                                                input logic wr);
    page_entry_t r;
    int          limit;
    int          w;
    int          b;
    logic        found;
    r = '0;
    found = 1'b0;
    if (fn == FN_ALLOC) begin
      if (entry != '0) begin
        r.frame = entry;
        r.status = ST_HAD_FRAME;
      end else begin
        limit = (int'(search_words) > NumWords) ? NumWords : int'(search_words);
        for (w = 0; w < limit && !found; w++) begin
          if (frame_bitmap[w] != '1) begin
            for (b = 0; b < WordBits && !found; b++) begin
              if (!frame_bitmap[w][b]) begin
                found = 1'b1;
                frame_bitmap[w][b] = 1'b1;
                r.frame = FrameW'(w * WordBits + b);
                r.present = 1'b1;
                r.writable = wr;
                r.user_mode = !kernel;
                r.status = ST_ALLOCATED;
              end
            end
          end
        end
        if (!found) r.status = ST_FULL;
      end
    end else if (entry == '0) begin
      r.status = ST_NOTHING;
    end else begin
      frame_bitmap[int'(entry) / WordBits][int'(entry) % WordBits] = 1'b0;
      r.status = ST_FREED;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    page_entry_t want;
    if (rst) begin
      for (int w = 0; w < NumWords; w++) frame_bitmap[w] = '0;
      search_words = ActiveReset;
      pending_entries.delete();
    end else begin
      if (cfg_valid && cfg_ready) search_words = cfg_data;
      if (in_valid && !in_stall) begin
        pending_entries.push_back(serve_request(request_fn_t'(func), entry_frame,
                                                kernel_page, grant_write));
      end
      if (out_valid && !out_stall) begin
        if (pending_entries.size() == 0) begin
          report($sformatf("result transaction with nothing outstanding: frame %0d status %0d",
                           frame, status));
        end else begin
          want = pending_entries.pop_front();
          if (frame !== want.frame)
            report($sformatf("frame: got %0d, expected %0d", frame, want.frame));
          if (present !== want.present)
            report($sformatf("present: got %b, expected %b", present, want.present));
          if (writable !== want.writable)
            report($sformatf("writable: got %b, expected %b", writable, want.writable));
          if (user_mode !== want.user_mode)
            report($sformatf("user_mode: got %b, expected %b", user_mode, want.user_mode));
          if (status !== want.status)
            report($sformatf("status: got %0d, expected %0d", status, want.status));
        end
      end
    end
    pending = pending_entries.size();
  end

endmodule

>>> tb/frame_bitmap_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// Frame bitmap allocator testbench
// Drives directed and random allocate and free requests over a range of
// search limits, with random gaps and result stalls, and reports the verdict
// of the checker that runs beside the block.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_unit_tb;
  import fba_pkg::*;
  import frame_bitmap_allocator_tb_pkg::*;

  localparam int StallLimit = 2000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               func;
  logic [FrameW-1:0]  entry_frame;
  logic               kernel_page;
  logic               grant_write;
  logic               out_valid;
  logic               out_stall;
  logic [FrameW-1:0]  frame;
  logic               present;
  logic               writable;
  logic               user_mode;
  logic [StatusW-1:0] status;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgW-1:0]    cfg_data;
  logic               quiet;
  int                 mismatches;
  int                 pending;
  int                 idle_cycles;

  frame_bitmap_allocator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .entry_frame  (entry_frame),
    .kernel_page  (kernel_page),
    .grant_write  (grant_write),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame        (frame),
    .present      (present),
    .writable     (writable),
    .user_mode    (user_mode),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  frame_bitmap_allocator_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .entry_frame  (entry_frame),
    .kernel_page  (kernel_page),
    .grant_write  (grant_write),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame        (frame),
    .present      (present),
    .writable     (writable),
    .user_mode    (user_mode),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 35);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("frame_bitmap_allocator_unit_tb: errors");
      $finish;
    end
  end

  task automatic send_request(input request_fn_t fn, input logic [FrameW-1:0] entry,
                              input logic kernel, input logic wr);
    while (!quiet && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    entry_frame <= entry;
    kernel_page <= kernel;
    grant_write <= wr;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic set_search_words(input logic [CfgW-1:0] words);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= words;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_request(input int alloc_pct, input int span);
    request_fn_t         fn;
    logic [FrameW-1:0]   entry;
    fn = ($urandom_range(0, 99) < alloc_pct) ? FN_ALLOC : FN_FREE;
    if (fn == FN_ALLOC)
      entry = ($urandom_range(0, 99) < 85) ? '0 : FrameW'($urandom_range(1, NumFrames - 1));
    else if ($urandom_range(0, 99) < 70)
      entry = FrameW'($urandom_range(0, span - 1));
    else
      entry = FrameW'($urandom);
    send_request(fn, entry, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned settings [16];
    int          words;
    int          count;
    int          alloc_pct;
    settings = '{1, 2, 128, 255, 3, 0, 1, 0, 128, 64, 16, 1, 200, 128, 8, 4};
    settings[7] = $urandom_range(1, NumWords);
    quiet <= 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= FN_ALLOC;
    entry_frame <= '0;
    kernel_page <= 1'b0;
    grant_write <= 1'b0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    idle_cycles <= 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_request(FN_ALLOC, '0, 1'b0, 1'b0);
    send_request(FN_ALLOC, '0, 1'b1, 1'b1);
    send_request(FN_ALLOC, '0, 1'b0, 1'b1);
    send_request(FN_ALLOC, '0, 1'b1, 1'b0);
    send_request(FN_ALLOC, 12'hFFF, 1'b1, 1'b1);
    send_request(FN_ALLOC, 12'h001, 1'b0, 1'b0);
    send_request(FN_FREE, '0, 1'b1, 1'b1);
    send_request(FN_FREE, 12'h002, 1'b0, 1'b0);
    send_request(FN_ALLOC, '0, 1'b0, 1'b1);
    send_request(FN_FREE, 12'hFFF, 1'b0, 1'b0);
    send_request(FN_FREE, 12'h001, 1'b1, 1'b1);
    send_request(FN_ALLOC, '0, 1'b1, 1'b1);
    send_request(FN_FREE, 12'hAAA, 1'b1, 1'b0);
    send_request(FN_ALLOC, 12'h555, 1'b0, 1'b1);
    set_search_words(8'd0);
    send_request(FN_ALLOC, '0, 1'b0, 1'b1);
    send_request(FN_FREE, 12'h003, 1'b0, 1'b0);
    set_search_words(8'hFF);
    send_request(FN_ALLOC, '0, 1'b1, 1'b0);

    for (int p = 0; p < 16; p++) begin
      set_search_words(CfgW'(settings[p]));
      quiet <= (p == 4 || p == 5);
      words = (settings[p] == 0) ? 1 : (settings[p] > NumWords ? NumWords : settings[p]);
      count = (p == 2) ? 200 : 56;
      alloc_pct = (p == 2) ? 92 : ((p % 2 == 0) ? 75 : 55);
      for (int i = 0; i < count; i++) random_request(alloc_pct, words * WordBits);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (140) @(posedge clk);
    if (mismatches == 0)
      $display("frame_bitmap_allocator_unit_tb: clean");
    else
      $display("frame_bitmap_allocator_unit_tb: errors");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/fba_pkg.sv
hdl/fba_datapath.sv
hdl/fba_controller.sv
hdl/frame_bitmap_allocator_unit.sv
tb/frame_bitmap_allocator_tb_pkg.sv
tb/frame_bitmap_allocator_checker.sv
tb/frame_bitmap_allocator_unit_tb.sv
